// File: rtl/core/sn_pkg.sv
// Shared types, constants and helpers for the simplex noise pipeline.
package sn_pkg;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_EVAL2 = 2'd1,
        FN_EVAL3 = 2'd2
    } t_func;

    typedef struct packed {
        logic is3d;
        logic live;
    } t_ctl;

    // Q32 skew / unskew constants
    localparam logic signed [65:0] F2C    = 66'sd1572067139;
    localparam logic signed [71:0] G2M    = 72'sd907633386;
    localparam logic signed [35:0] G2     = 36'sd907633386;
    localparam logic signed [35:0] G2X2   = 36'sd1815266771;
    localparam logic signed [35:0] G3     = 36'sd715827883;
    localparam logic signed [35:0] G3X2   = 36'sd1431655765;
    localparam logic signed [35:0] G3X3   = 36'sd2147483648;
    localparam logic signed [35:0] ONE_Q32 = 36'sd4294967296;
    // floor(r * 2^31 / 3) for remainder r of one and two
    localparam logic signed [35:0] UN_R1  = 36'sd715827882;
    localparam logic signed [35:0] UN_R2  = 36'sd1431655765;
    // radius squared, Q56
    localparam logic signed [65:0] R2_2D  = 66'sd36028797018963968;
    localparam logic signed [65:0] R2_3D  = 66'sd43234556422756761;
    localparam logic [62:0]        DIV3_MUL = 63'd1431655766;

    // floor(n / 3), exact for n below 2^31
    function automatic logic [30:0] div3(input logic [30:0] n);
        logic [62:0] p;
        p = {32'd0, n} * DIV3_MUL;
        return p[62:32];
    endfunction

endpackage

// File: rtl/core/sn_if.sv
// Valid/ready channel interfaces for noise requests and noise results.
interface sn_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [7:0]         table_index;
    logic [7:0]         table_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;

    modport source (output valid, func, table_index, table_value, coord_x, coord_y, coord_z,
                    input ready);
    modport sink (input valid, func, table_index, table_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface sn_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface

// File: rtl/core/sn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/sn_corner.sv
// One simplex corner: falloff t^4 and gradient dot product, stages 8 to 12.
module sn_corner (
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic signed [31:0] i_c,
    input  sn_pkg::t_ctl       i_ctl,
    input  logic [7:0]         i_hash,
    output logic signed [63:0] o_contrib
);
    import sn_pkg::*;

    logic signed [63:0] r8_sqa, r8_sqb, r8_sqc;
    logic signed [31:0] r8_a, r8_b, r8_c, r9_a, r9_b, r9_c, r10_a, r10_b, r10_c;
    t_ctl               r8_ctl, r9_ctl, r10_ctl;
    logic [29:0]        r9_t30, r10_t2, r11_t4;
    logic               r9_tpos, r10_tpos, r11_keep;
    logic signed [33:0] r11_grad;
    logic signed [63:0] r12_contrib;

    logic signed [63:0] n8_sqc;
    logic signed [65:0] n9_t;
    logic [59:0]        n10_p, n11_p;
    logic signed [33:0] n11_grad, n11_x, n11_y, n11_z, n11_u, n11_v;
    logic [3:0]         n11_h;
    logic signed [63:0] n12_p;

    always_comb begin
        n8_sqc = i_ctl.is3d ? i_c * i_c : 64'sd0;
        n9_t   = (R2_2D & {66{~r8_ctl.is3d}}) + (R2_3D & {66{r8_ctl.is3d}})
                 - 66'(r8_sqa) - 66'(r8_sqb) - 66'(r8_sqc);
        n10_p  = {30'd0, r9_t30} * {30'd0, r9_t30};
        n11_p  = {30'd0, r10_t2} * {30'd0, r10_t2};
    end

    // gradient pick by hash
    always_comb begin
        n11_x = 34'(r10_a);
        n11_y = 34'(r10_b);
        n11_z = 34'(r10_c);
        n11_h = i_hash[3:0];
        if (r10_ctl.is3d) begin
            n11_u = (n11_h < 4'd8) ? n11_x : n11_y;
            if (n11_h < 4'd4) begin
                n11_v = n11_y;
            end else if (n11_h == 4'd12 || n11_h == 4'd14) begin
                n11_v = n11_x;
            end else begin
                n11_v = n11_z;
            end
        end else begin
            n11_h[3] = 1'b0;
            n11_u = (n11_h < 4'd4) ? n11_x : n11_y;
            n11_v = (n11_h < 4'd4) ? (n11_y <<< 1) : (n11_x <<< 1);
        end
        n11_grad = (n11_h[0] ? -n11_u : n11_u) + (n11_h[1] ? -n11_v : n11_v);
        n12_p    = 64'(signed'({1'b0, r11_t4})) * 64'(r11_grad);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r8_sqa  <= i_a * i_a;
            r8_sqb  <= i_b * i_b;
            r8_sqc  <= n8_sqc;
            r8_a    <= i_a;
            r8_b    <= i_b;
            r8_c    <= i_c;
            r8_ctl  <= i_ctl;

            r9_t30  <= n9_t[55:26];
            r9_tpos <= ~n9_t[65];
            r9_a    <= r8_a;
            r9_b    <= r8_b;
            r9_c    <= r8_c;
            r9_ctl  <= r8_ctl;

            r10_t2   <= n10_p[59:30];
            r10_tpos <= r9_tpos;
            r10_a    <= r9_a;
            r10_b    <= r9_b;
            r10_c    <= r9_c;
            r10_ctl  <= r9_ctl;

            r11_t4   <= n11_p[59:30];
            r11_grad <= n11_grad;
            r11_keep <= r10_tpos & r10_ctl.live;

            r12_contrib <= r11_keep ? n12_p : 64'sd0;
        end
    end

    assign o_contrib = r12_contrib;
endmodule

// File: rtl/core/simplex_noise_2d_3d.sv
// Simplex noise 2D/3D evaluator with loadable permutation table, 14-stage pipeline.
//
//  channel | dir | port  | carries
//  --------+-----+-------+----------------------------------------------------
//  request | in  | i_in  | func, table_index, table_value, coord_x/y/z
//  result  | out | o_out | noise_value (one per evaluate item)
//
// One evaluate item per cycle while the output register is not held.
// A load item writes all twelve table copies at acceptance; it waits while any
// evaluate item sits in stages 1 to 9, where the three hash lookups happen.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears the valid bits only; the table is undefined until loaded.
module simplex_noise_2d_3d #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sn_in_if.sink      i_in,
    sn_out_if.source   o_out
);
    import sn_pkg::*;

    localparam int FB   = COORD_FRAC_BITS;
    localparam int IW   = 36 - FB;
    localparam int NST  = 14;
    localparam logic signed [35:0] OFS1  = 36'sd3 <<< (IW - 1);
    localparam logic signed [35:0] HALF1 = 36'sd1 <<< (IW - 1);
    localparam logic signed [35:0] OFS2  = 36'sd3 <<< (IW + 1);
    localparam logic signed [35:0] HALF2 = 36'sd1 <<< (IW + 1);

    logic [NST:1] r_vld;
    logic [NST:1] r_m;
    logic         w_adv, w_busy, w_acc, w_load, w_eval;

    assign w_adv  = ~r_vld[NST] | o_out.ready;
    assign w_busy = |r_vld[9:1];
    assign i_in.ready = w_adv & ((i_in.func != FN_LOAD) | ~w_busy);
    assign w_acc  = i_in.valid & i_in.ready;
    assign w_load = w_acc & (i_in.func == FN_LOAD);
    assign w_eval = w_acc & ((i_in.func == FN_EVAL2) | (i_in.func == FN_EVAL3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-1:1], w_eval};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m <= {r_m[NST-1:1], i_in.func == FN_EVAL3};
        end
    end

    // stage 1: sums
    logic signed [31:0] r1_x, r1_y, r1_z, r2_x, r2_y, r2_z, r3_x, r3_y, r3_z;
    logic signed [31:0] r4_x, r4_y, r4_z, r5_x, r5_y, r5_z;
    logic signed [32:0] r1_sxy;
    logic signed [35:0] r1_nx, r1_ny, r1_nz, n1_tot;

    always_comb begin
        n1_tot = 36'(i_in.coord_x) + 36'(i_in.coord_y) + 36'(i_in.coord_z);
    end

    // stage 2: skew product (2D), cell division by three (3D)
    logic signed [65:0] n2_shp;
    logic signed [35:0] n2_nx, n2_ny, n2_nz;
    logic signed [33:0] r2_sh;
    logic [30:0]        r2_ux, r2_uy, r2_uz;

    always_comb begin
        n2_shp = 66'(r1_sxy) * F2C;
        n2_nx  = (r1_nx >>> FB) + OFS1;
        n2_ny  = (r1_ny >>> FB) + OFS1;
        n2_nz  = (r1_nz >>> FB) + OFS1;
    end

    // stage 3: cell indices
    logic signed [35:0]   n3_sx, n3_sy, n3_ix, n3_iy, n3_iz;
    logic signed [IW-1:0] r3_ii, r3_jj, r3_kk, r4_ii, r4_jj, r4_kk, r5_ii, r5_jj, r5_kk;

    always_comb begin
        n3_sx = (36'(r2_x) + 36'(r2_sh)) >>> FB;
        n3_sy = (36'(r2_y) + 36'(r2_sh)) >>> FB;
        n3_ix = signed'(36'(r2_ux)) - HALF1;
        n3_iy = signed'(36'(r2_uy)) - HALF1;
        n3_iz = signed'(36'(r2_uz)) - HALF1;
    end

    // stage 4: unskew product (2D), index sum over three (3D)
    logic signed [35:0]   n4_s, n4_n;
    logic signed [71:0]   n4_p;
    logic signed [35:0]   r4_un2;
    logic signed [IW+1:0] r4_s;
    logic [30:0]          r4_u;

    always_comb begin
        n4_s = 36'(r3_ii) + 36'(r3_jj) + (r_m[3] ? 36'(r3_kk) : 36'sd0);
        n4_p = 72'(n4_s) * G2M;
        n4_n = n4_s + OFS2;
    end

    // stage 5: unskew offset
    logic signed [35:0] n5_q, n5_r, n5_un3, r5_un;

    always_comb begin
        n5_q   = signed'(36'(r4_u)) - HALF2;
        n5_r   = 36'(r4_s) - ((n5_q <<< 1) + n5_q);
        n5_un3 = n5_q <<< 31;
        if (n5_r[1:0] == 2'd1) begin
            n5_un3 = n5_un3 + UN_R1;
        end else if (n5_r[1:0] == 2'd2) begin
            n5_un3 = n5_un3 + UN_R2;
        end
    end

    // stage 6: first corner offsets in Q32
    logic signed [35:0] r6_x0, r6_y0, r6_z0;
    logic [7:0]         r6_ii, r6_jj, r6_kk;

    // stage 7: corner ordering and per-corner offsets
    logic [2:0]         n7_o [4];
    logic signed [35:0] n7_g [4];
    logic signed [35:0] n7_d [4][3];
    logic [2:0]         r7_o [4];
    logic signed [31:0] r7_a [4][3];
    logic [7:0]         r7_ii, r7_jj, r7_kk;

    always_comb begin
        n7_o[0] = 3'b000;
        n7_o[3] = 3'b111;
        if (r_m[6]) begin
            n7_g[0] = 36'sd0;
            n7_g[1] = G3;
            n7_g[2] = G3X2;
            n7_g[3] = G3X3;
            if (r6_x0 >= r6_y0) begin
                if (r6_y0 >= r6_z0) begin
                    n7_o[1] = 3'b100;
                    n7_o[2] = 3'b110;
                end else if (r6_x0 >= r6_z0) begin
                    n7_o[1] = 3'b100;
                    n7_o[2] = 3'b101;
                end else begin
                    n7_o[1] = 3'b001;
                    n7_o[2] = 3'b101;
                end
            end else begin
                if (r6_y0 < r6_z0) begin
                    n7_o[1] = 3'b001;
                    n7_o[2] = 3'b011;
                end else if (r6_x0 < r6_z0) begin
                    n7_o[1] = 3'b010;
                    n7_o[2] = 3'b011;
                end else begin
                    n7_o[1] = 3'b010;
                    n7_o[2] = 3'b110;
                end
            end
        end else begin
            n7_g[0] = 36'sd0;
            n7_g[1] = G2;
            n7_g[2] = G2X2;
            n7_g[3] = G3X3;
            n7_o[1] = (r6_x0 > r6_y0) ? 3'b100 : 3'b010;
            n7_o[2] = 3'b110;
        end
        for (int c = 0; c < 4; c++) begin
            n7_d[c][0] = r6_x0 - (n7_o[c][2] ? ONE_Q32 : 36'sd0) + n7_g[c];
            n7_d[c][1] = r6_y0 - (n7_o[c][1] ? ONE_Q32 : 36'sd0) + n7_g[c];
            n7_d[c][2] = r6_z0 - (n7_o[c][0] ? ONE_Q32 : 36'sd0) + n7_g[c];
        end
    end

    // stages 8 and 9 carry hash inputs
    logic [2:0] r8_o [4];
    logic [2:0] r9_o [4];
    logic [7:0] r8_ii, r8_jj, r9_ii;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_x   <= i_in.coord_x;
            r1_y   <= i_in.coord_y;
            r1_z   <= i_in.coord_z;
            r1_sxy <= 33'(i_in.coord_x) + 33'(i_in.coord_y);
            r1_nx  <= (36'(i_in.coord_x) <<< 1) + 36'(i_in.coord_x) + n1_tot;
            r1_ny  <= (36'(i_in.coord_y) <<< 1) + 36'(i_in.coord_y) + n1_tot;
            r1_nz  <= (36'(i_in.coord_z) <<< 1) + 36'(i_in.coord_z) + n1_tot;

            r2_x  <= r1_x;
            r2_y  <= r1_y;
            r2_z  <= r1_z;
            r2_sh <= n2_shp[65:32];
            r2_ux <= div3(n2_nx[30:0]);
            r2_uy <= div3(n2_ny[30:0]);
            r2_uz <= div3(n2_nz[30:0]);

            r3_x  <= r2_x;
            r3_y  <= r2_y;
            r3_z  <= r2_z;
            r3_ii <= r_m[2] ? n3_ix[IW-1:0] : n3_sx[IW-1:0];
            r3_jj <= r_m[2] ? n3_iy[IW-1:0] : n3_sy[IW-1:0];
            r3_kk <= n3_iz[IW-1:0];

            r4_x   <= r3_x;
            r4_y   <= r3_y;
            r4_z   <= r3_z;
            r4_ii  <= r3_ii;
            r4_jj  <= r3_jj;
            r4_kk  <= r3_kk;
            r4_un2 <= n4_p[35:0];
            r4_s   <= n4_s[IW+1:0];
            r4_u   <= div3(n4_n[30:0]);

            r5_x  <= r4_x;
            r5_y  <= r4_y;
            r5_z  <= r4_z;
            r5_ii <= r4_ii;
            r5_jj <= r4_jj;
            r5_kk <= r4_kk;
            r5_un <= r_m[4] ? n5_un3 : r4_un2;

            r6_x0 <= (36'(r5_x) <<< (32 - FB)) - {r5_ii[3:0], 32'd0} + r5_un;
            r6_y0 <= (36'(r5_y) <<< (32 - FB)) - {r5_jj[3:0], 32'd0} + r5_un;
            r6_z0 <= (36'(r5_z) <<< (32 - FB)) - {r5_kk[3:0], 32'd0} + r5_un;
            r6_ii <= r5_ii[7:0];
            r6_jj <= r5_jj[7:0];
            r6_kk <= r5_kk[7:0];

            for (int c = 0; c < 4; c++) begin
                r7_o[c] <= n7_o[c];
                r8_o[c] <= r7_o[c];
                r9_o[c] <= r8_o[c];
                for (int k = 0; k < 3; k++) begin
                    r7_a[c][k] <= n7_d[c][k][35:4];
                end
            end
            r7_ii <= r6_ii;
            r7_jj <= r6_jj;
            r7_kk <= r6_kk;
            r8_ii <= r7_ii;
            r8_jj <= r7_jj;
            r9_ii <= r8_ii;
        end
    end

    // hash lookups: three table levels, one copy per corner and level
    logic [7:0]         w_hk [4];
    logic [7:0]         w_hj [4];
    logic [7:0]         w_h  [4];
    logic signed [63:0] w_contrib [4];
    t_ctl               w_ctl [4];

    for (genvar c = 0; c < 4; c++) begin : g_corner
        sn_ram #(.WIDTH(8), .DEPTH(256)) u_ram_k (
            .i_clk   (i_clk),
            .i_we    (w_load),
            .i_waddr (i_in.table_index),
            .i_wdata (i_in.table_value),
            .i_re    (w_adv),
            .i_raddr (r7_kk + {7'd0, r7_o[c][0]}),
            .o_rdata (w_hk[c])
        );
        sn_ram #(.WIDTH(8), .DEPTH(256)) u_ram_j (
            .i_clk   (i_clk),
            .i_we    (w_load),
            .i_waddr (i_in.table_index),
            .i_wdata (i_in.table_value),
            .i_re    (w_adv),
            .i_raddr (r8_jj + {7'd0, r8_o[c][1]} + (r_m[8] ? w_hk[c] : 8'd0)),
            .o_rdata (w_hj[c])
        );
        sn_ram #(.WIDTH(8), .DEPTH(256)) u_ram_i (
            .i_clk   (i_clk),
            .i_we    (w_load),
            .i_waddr (i_in.table_index),
            .i_wdata (i_in.table_value),
            .i_re    (w_adv),
            .i_raddr (r9_ii + {7'd0, r9_o[c][2]} + w_hj[c]),
            .o_rdata (w_h[c])
        );

        assign w_ctl[c].is3d = r_m[7];
        assign w_ctl[c].live = (c != 3) | r_m[7];

        sn_corner u_corner (
            .i_clk     (i_clk),
            .i_adv     (w_adv),
            .i_a       (r7_a[c][0]),
            .i_b       (r7_a[c][1]),
            .i_c       (r7_a[c][2]),
            .i_ctl     (w_ctl[c]),
            .i_hash    (w_h[c]),
            .o_contrib (w_contrib[c])
        );
    end

    // stages 13 and 14: sum, scale, map to [0,1], saturate
    logic signed [63:0] r13_sum;
    logic signed [45:0] n14_sf, n14_v;
    logic [15:0]        n14_out, r14_out;

    always_comb begin
        n14_sf = 46'(signed'(r13_sum[63:26]));
        n14_v  = (n14_sf <<< 5) + (r_m[13] ? 46'sd0 : (n14_sf <<< 3)) + 46'sd4294967296;
        if (n14_v[45]) begin
            n14_out = 16'd0;
        end else if (|n14_v[44:33]) begin
            n14_out = 16'hFFFF;
        end else begin
            n14_out = n14_v[32:17];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r13_sum <= w_contrib[0] + w_contrib[1] + w_contrib[2] + w_contrib[3];
            r14_out <= n14_out;
        end
    end

    assign o_out.valid       = r_vld[NST];
    assign o_out.noise_value = r14_out;
endmodule

// File: rtl/core/sn_chk.sv
// Port-level checker for the simplex noise block, bound to the top level.
module sn_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_noise
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_noise))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !(i_in_valid && i_in_ready))
        else $error("item taken while pipeline held");
endmodule

bind simplex_noise_2d_3d sn_chk u_sn_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_noise (o_out.noise_value)
);
